FILE: rtl/core/waveform_baseline_truncated_mean_rms_defines.svh
// Assertion macros shared by the checker of the baseline estimator.
// Depends on aclk and aresetn being visible where a macro is used.
`ifndef WAVEFORM_BASELINE_TRUNCATED_MEAN_RMS_DEFINES_SVH
`define WAVEFORM_BASELINE_TRUNCATED_MEAN_RMS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define WBTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define WBTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wbtm_pkg.sv
// Package of the truncated-mean baseline estimator: transaction types,
// fixed widths and constants. No dependencies.
package wbtm_pkg;

    localparam int ADC_BITS    = 12;
    localparam int HIST_DEPTH  = 1 << ADC_BITS;
    localparam int CNT_W       = 15;
    localparam int MAX_SAMPLES = 16384;
    localparam logic [7:0] TRUNC_RESET = 8'd38;

    // Iterative divider and square root widths
    localparam int DIV_NUM_W = 69;
    localparam int DIV_DEN_W = 30;
    localparam int SQRT_W    = 42;

    typedef struct packed {
        logic [11:0] sample;
        logic        last_sample;
    } in_item_t;

    typedef struct packed {
        logic [19:0] trunc_mean;
        logic [18:0] trunc_rms;
        logic [11:0] spread;
        logic [14:0] kept_count;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage

FILE: rtl/core/wbtm_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module wbtm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/wbtm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wbtm_pkg for widths and the request struct.
module wbtm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wbtm_pkg::div_req_t             req,
    output logic                           done,
    output logic [wbtm_pkg::DIV_NUM_W-1:0] quot
);

    localparam int NW = wbtm_pkg::DIV_NUM_W;
    localparam int DW = wbtm_pkg::DIV_DEN_W;
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   sh_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic            fits;

    // Shift in the next numerator bit and try the subtraction
    always_comb begin
        trial = {rem_reg[DW-1:0], sh_reg[NW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                sh_reg   <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                cnt_reg  <= CNTW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial - {1'b0, den_reg} : trial;
                sh_reg  <= {sh_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

FILE: rtl/core/wbtm_sqrt.sv
// Bit-pair integer square root, floor of the exact root, one step per cycle.
// Depends on wbtm_pkg for the operand width.
module wbtm_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wbtm_pkg::SQRT_W-1:0]   x,
    output logic                          done,
    output logic [wbtm_pkg::SQRT_W/2-1:0] root
);

    localparam int W = wbtm_pkg::SQRT_W;

    logic [W-1:0] x_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] bit_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x;
                res_reg  <= '0;
                bit_reg  <= W'(1) << (W - 2);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // Take the bit pair when the remainder allows it
                if (x_reg >= trial) begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[W/2-1:0];

endmodule

FILE: rtl/core/waveform_baseline_truncated_mean_rms.sv
// Top level of the truncated-mean and RMS baseline estimator.
// Depends on wbtm_pkg, wbtm_ram, wbtm_div and wbtm_sqrt.
// Each sample reads its histogram bin in ST_IDLE and writes it back in ST_UPD; s_ready is
// low meanwhile, so a new sample is taken only once the last one is written back.
// Reset clears all 4096 bins; after each result the bins from the minimum to the maximum
// value seen (R = max-min+1 bins) are cleared first.
module waveform_baseline_truncated_mean_rms #(
    parameter int NEIGHBOR_SPAN = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  wbtm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wbtm_pkg::out_item_t m_data
);

    localparam int AW     = wbtm_pkg::ADC_BITS;
    localparam int CW     = wbtm_pkg::CNT_W;
    localparam int BW     = AW + 8;
    localparam int PW     = AW + 2;
    localparam int NB_CNT = 2 * NEIGHBOR_SPAN + 1;
    localparam int NB_IW  = $clog2(NB_CNT);
    localparam int MSUM_W = AW + CW;
    localparam int SS_W   = 2 * BW + CW;
    localparam int SQ9_W  = SS_W + 4;
    localparam int PSUM_W = AW + CW - 1;
    localparam int QSUM_W = 2 * AW + CW - 1;
    localparam int KQ_W   = CW + QSUM_W;
    localparam int NW     = wbtm_pkg::DIV_NUM_W;
    localparam int DW     = wbtm_pkg::DIV_DEN_W;
    localparam int SW     = wbtm_pkg::SQRT_W;
    localparam logic [AW-1:0] VMAX = {AW{1'b1}};
    localparam logic [BW-1:0] THRESH_D = BW'(1024);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_UPD, ST_NB, ST_NB_LAST, ST_BDIV, ST_BWAIT,
        ST_SWEEP, ST_DRAIN, ST_KF, ST_WRD, ST_WACC, ST_FIN1, ST_FIN2,
        ST_FIN3, ST_FIN4, ST_FIN5, ST_MWAIT, ST_VDIV, ST_VWAIT, ST_SQWAIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [7:0]    trunc_fraction_reg;
    logic [AW-1:0] clr_addr_reg, clr_end_reg;
    logic [AW-1:0] mode_value_reg, min_seen_reg, max_seen_reg;
    logic [CW-1:0] mode_count_reg, samples_seen_reg;
    logic [AW-1:0] cur_v_reg;
    logic          cur_last_reg, cur_ok_reg;

    // Neighbour phase
    logic [NB_IW-1:0]     nb_idx_reg;
    logic                 nb_pend_reg;
    logic [AW-1:0]        nb_pos_d_reg;
    logic [MSUM_W-1:0]    msum_reg;
    logic [CW-1:0]        mcnt_reg;
    logic signed [PW-1:0] nb_pos;
    logic                 nb_ok;

    // Sweeps
    logic [BW-1:0]      base_reg;
    logic [AW-1:0]      sw_addr_reg, sw_a1_reg;
    logic               sw_phase_reg;
    logic               sw_v1_reg, sw_v2_reg, sw_v3_reg, sw_v4_reg;
    logic [BW-1:0]      sw_d1_reg;
    logic [CW-1:0]      sw_h1_reg, sw_h2_reg, sw_h3_reg;
    logic [2*BW-1:0]    sw_dd2_reg;
    logic               sw_near2_reg, sw_near3_reg;
    logic [CW+BW-1:0]   sw_p0_reg, sw_p1_reg;
    logic [CW+BW:0]     sw_nd3_reg;
    logic [SS_W-1:0]    sumsq_reg;
    logic [SQ9_W-1:0]   sq9_reg;
    logic [CW-1:0]      within_reg;

    // Walk and final arithmetic
    logic [CW-1:0]        k_reg, remaining_reg;
    logic signed [PW-1:0] walk_lo_reg;
    logic [PW-1:0]        walk_hi_reg;
    logic [AW-1:0]        walk_bin_reg;
    logic [2*AW-1:0]      walk_bsq_reg;
    logic [PSUM_W-1:0]    psum_reg;
    logic [QSUM_W-1:0]    qsum_reg;
    logic [CW+19:0]       ma_reg;
    logic [CW+QSUM_W-21:0] mb_reg;
    logic [2*PSUM_W-1:0]  pp_reg;
    logic [KQ_W-1:0]      var_reg;
    logic [DW-1:0]        kk_reg;
    logic [19:0]          mean_reg;
    logic [18:0]          rms_reg;

    logic                 m_valid_reg;
    wbtm_pkg::out_item_t  m_data_reg;

    // Units
    wbtm_pkg::div_req_t  div_req_reg;
    logic                div_done;
    logic [NW-1:0]       div_quot;
    logic                sq_start_reg;
    logic                sq_done;
    logic [SW/2-1:0]     sq_root;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata, ram_rdata;

    // Walk steering
    logic          walk_lo_ok, walk_hi_ok, walk_go, take_lo;
    logic [AW-1:0] walk_bin;
    logic [CW-1:0] walk_h;
    logic [PSUM_W-1:0] walk_pb;
    logic [QSUM_W-1:0] walk_qb;
    logic [CW+8:0]     kfloor_prod;
    logic [CW-1:0]     kfloor;
    logic [CW-1:0]     hist_inc;
    logic [KQ_W-1:0]   kq;

    function automatic logic [BW-1:0] dist_of(logic [AW-1:0] v, logic [BW-1:0] b);
        logic [BW-1:0] p;
        p = {v, 8'b0};
        return (p >= b) ? p - b : b - p;
    endfunction

    wbtm_ram #(.WIDTH(CW), .DEPTH(wbtm_pkg::HIST_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wbtm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    wbtm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start_reg),
        .x       (div_quot[SW-1:0]),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Neighbour address and range check
    always_comb begin
        nb_pos = $signed({2'b00, mode_value_reg}) + $signed({{(PW-NB_IW){1'b0}}, nb_idx_reg})
                 - $signed(PW'(NEIGHBOR_SPAN));
        nb_ok  = (nb_pos[PW-1:AW] == '0);
    end

    // Choose the next bin of the outward walk, lower value first on ties
    always_comb begin
        walk_lo_ok = !walk_lo_reg[PW-1];
        walk_hi_ok = walk_hi_reg <= {2'b00, VMAX};
        walk_go    = (remaining_reg != '0) && (walk_lo_ok || walk_hi_ok);
        if (!walk_lo_ok) begin
            take_lo = 1'b0;
        end else if (!walk_hi_ok) begin
            take_lo = 1'b1;
        end else begin
            take_lo = dist_of(walk_lo_reg[AW-1:0], base_reg)
                      <= dist_of(walk_hi_reg[AW-1:0], base_reg);
        end
        walk_bin = take_lo ? walk_lo_reg[AW-1:0] : walk_hi_reg[AW-1:0];
        walk_h   = (ram_rdata < remaining_reg) ? ram_rdata : remaining_reg;
        walk_pb  = PSUM_W'(walk_h * walk_bin_reg);
        walk_qb  = QSUM_W'(walk_h * walk_bsq_reg);
    end

    always_comb begin
        kfloor_prod = (9'd256 - {1'b0, trunc_fraction_reg}) * samples_seen_reg;
        kfloor      = kfloor_prod[CW+7:8];
        hist_inc    = ram_rdata + 1'b1;
        kq          = KQ_W'(ma_reg) + (KQ_W'(mb_reg) << 20);
    end

    // Histogram RAM port steering
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = sw_addr_reg;
        ram_we    = 1'b0;
        ram_waddr = cur_v_reg;
        ram_wdata = hist_inc;
        case (state_reg)
            ST_IDLE: begin
                ram_re    = s_valid;
                ram_raddr = s_data.sample[AW-1:0];
            end
            ST_UPD: begin
                ram_we = cur_ok_reg;
            end
            ST_NB: begin
                ram_re    = nb_ok;
                ram_raddr = nb_pos[AW-1:0];
            end
            ST_SWEEP: begin
                ram_re = 1'b1;
            end
            ST_WRD: begin
                ram_re    = walk_go;
                ram_raddr = walk_bin;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Sequencer, accumulators and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLEAR;
            trunc_fraction_reg <= wbtm_pkg::TRUNC_RESET;
            clr_addr_reg       <= '0;
            clr_end_reg        <= VMAX;
            mode_value_reg     <= '0;
            mode_count_reg     <= '0;
            min_seen_reg       <= VMAX;
            max_seen_reg       <= '0;
            samples_seen_reg   <= '0;
            nb_pend_reg        <= 1'b0;
            sw_v1_reg          <= 1'b0;
            sw_v2_reg          <= 1'b0;
            sw_v3_reg          <= 1'b0;
            sw_v4_reg          <= 1'b0;
            div_req_reg.start  <= 1'b0;
            sq_start_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            // Pulse the unit starts for one cycle and flag the neighbour reads for the accumulation
            div_req_reg.start <= (state_reg == ST_BDIV) || (state_reg == ST_VDIV)
                                 || ((state_reg == ST_FIN5) && (k_reg != '0));
            sq_start_reg      <= (state_reg == ST_VWAIT) && div_done;
            nb_pend_reg       <= (state_reg == ST_NB) && nb_ok;

            if (cfg_wr_en) begin
                trunc_fraction_reg <= cfg_wr_data;
            end
            // Raise the result on publish, drop it once taken
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Neighbour accumulation, in the cycle after the read
            if (nb_pend_reg && ({3'b000, ram_rdata} * 3'd5 > {3'b000, mode_count_reg})) begin
                msum_reg <= msum_reg + MSUM_W'(nb_pos_d_reg * ram_rdata);
                mcnt_reg <= mcnt_reg + ram_rdata;
            end

            // Sweep pipeline: distance, square, weight, accumulate
            sw_v1_reg <= (state_reg == ST_SWEEP);
            sw_a1_reg <= sw_addr_reg;
            sw_v2_reg <= sw_v1_reg;
            sw_h1_reg <= ram_rdata;
            sw_d1_reg <= dist_of(sw_a1_reg, base_reg);
            sw_v3_reg <= sw_v2_reg;
            sw_dd2_reg   <= sw_d1_reg * sw_d1_reg;
            sw_h2_reg    <= sw_h1_reg;
            sw_near2_reg <= sw_d1_reg <= THRESH_D;
            sw_v4_reg <= sw_v3_reg;
            sw_p0_reg    <= sw_h2_reg * sw_dd2_reg[BW-1:0];
            sw_p1_reg    <= sw_h2_reg * sw_dd2_reg[2*BW-1:BW];
            sw_nd3_reg   <= samples_seen_reg * sw_dd2_reg[BW:0];
            sw_near3_reg <= sw_near2_reg;
            sw_h3_reg    <= sw_h2_reg;
            if (sw_v4_reg) begin
                if (!sw_phase_reg) begin
                    sumsq_reg <= sumsq_reg + SS_W'(sw_p0_reg) + (SS_W'(sw_p1_reg) << BW);
                end else if (sw_near3_reg && ({(CW+BW+1)'(0), sw_nd3_reg, 2'b00} <= {
                             (CW+BW+3)'(0), sq9_reg} )) begin
                    within_reg <= within_reg + sw_h3_reg;
                end
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == clr_end_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_v_reg    <= s_data.sample[AW-1:0];
                        cur_last_reg <= s_data.last_sample;
                        cur_ok_reg   <= samples_seen_reg < CW'(wbtm_pkg::MAX_SAMPLES);
                        state_reg    <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    // Count the sample while under MAX_SAMPLES, track mode and extremes
                    if (cur_ok_reg) begin
                        if (hist_inc > mode_count_reg) begin
                            mode_count_reg <= hist_inc;
                            mode_value_reg <= cur_v_reg;
                        end
                        if (cur_v_reg < min_seen_reg) begin
                            min_seen_reg <= cur_v_reg;
                        end
                        if (cur_v_reg > max_seen_reg) begin
                            max_seen_reg <= cur_v_reg;
                        end
                        samples_seen_reg <= samples_seen_reg + 1'b1;
                    end
                    if (cur_last_reg) begin
                        nb_idx_reg <= '0;
                        msum_reg   <= '0;
                        mcnt_reg   <= '0;
                        state_reg  <= ST_NB;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_NB: begin
                    nb_pos_d_reg <= nb_pos[AW-1:0];
                    nb_idx_reg   <= nb_idx_reg + 1'b1;
                    if (nb_idx_reg == NB_IW'(NB_CNT - 1)) begin
                        state_reg <= ST_NB_LAST;
                    end
                end
                ST_NB_LAST: begin
                    state_reg <= ST_BDIV;
                end
                ST_BDIV: begin
                    div_req_reg.num   <= NW'({msum_reg, 8'b0}) + NW'(mcnt_reg >> 1);
                    div_req_reg.den   <= DW'(mcnt_reg);
                    state_reg         <= ST_BWAIT;
                end
                ST_BWAIT: begin
                    if (div_done) begin
                        base_reg     <= div_quot[BW-1:0];
                        sw_addr_reg  <= min_seen_reg;
                        sw_phase_reg <= 1'b0;
                        sumsq_reg    <= '0;
                        within_reg   <= '0;
                        state_reg    <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    sw_addr_reg <= sw_addr_reg + 1'b1;
                    if (sw_addr_reg == max_seen_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!sw_v1_reg && !sw_v2_reg && !sw_v3_reg && !sw_v4_reg) begin
                        if (!sw_phase_reg) begin
                            sq9_reg      <= (SQ9_W'(sumsq_reg) << 3) + SQ9_W'(sumsq_reg);
                            sw_phase_reg <= 1'b1;
                            sw_addr_reg  <= min_seen_reg;
                            state_reg    <= ST_SWEEP;
                        end else begin
                            state_reg <= ST_KF;
                        end
                    end
                end
                ST_KF: begin
                    k_reg         <= (kfloor > within_reg) ? kfloor : within_reg;
                    remaining_reg <= (kfloor > within_reg) ? kfloor : within_reg;
                    walk_lo_reg   <= $signed({2'b00, base_reg[BW-1:8]});
                    walk_hi_reg   <= {2'b00, base_reg[BW-1:8]} + 1'b1;
                    psum_reg      <= '0;
                    qsum_reg      <= '0;
                    state_reg     <= ST_WRD;
                end
                ST_WRD: begin
                    if (walk_go) begin
                        walk_bin_reg <= walk_bin;
                        walk_bsq_reg <= walk_bin * walk_bin;
                        if (take_lo) begin
                            walk_lo_reg <= walk_lo_reg - 1'b1;
                        end else begin
                            walk_hi_reg <= walk_hi_reg + 1'b1;
                        end
                        state_reg <= ST_WACC;
                    end else begin
                        state_reg <= ST_FIN1;
                    end
                end
                ST_WACC: begin
                    remaining_reg <= remaining_reg - walk_h;
                    psum_reg      <= psum_reg + walk_pb;
                    qsum_reg      <= qsum_reg + walk_qb;
                    state_reg     <= ST_WRD;
                end
                ST_FIN1: begin
                    k_reg     <= k_reg - remaining_reg;
                    state_reg <= ST_FIN2;
                end
                ST_FIN2: begin
                    ma_reg    <= k_reg * qsum_reg[19:0];
                    kk_reg    <= DW'(k_reg * k_reg);
                    state_reg <= ST_FIN3;
                end
                ST_FIN3: begin
                    mb_reg    <= k_reg * qsum_reg[QSUM_W-1:20];
                    state_reg <= ST_FIN4;
                end
                ST_FIN4: begin
                    pp_reg    <= psum_reg * psum_reg;
                    state_reg <= ST_FIN5;
                end
                ST_FIN5: begin
                    var_reg <= (kq >= KQ_W'(pp_reg)) ? kq - KQ_W'(pp_reg) : '0;
                    if (k_reg == '0) begin
                        mean_reg  <= '0;
                        rms_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        div_req_reg.num   <= NW'({psum_reg, 8'b0}) + NW'(k_reg >> 1);
                        div_req_reg.den   <= DW'(k_reg);
                        state_reg         <= ST_MWAIT;
                    end
                end
                ST_MWAIT: begin
                    if (div_done) begin
                        mean_reg  <= div_quot[19:0];
                        state_reg <= ST_VDIV;
                    end
                end
                ST_VDIV: begin
                    div_req_reg.num   <= {var_reg, 16'b0};
                    div_req_reg.den   <= kk_reg;
                    state_reg         <= ST_VWAIT;
                end
                ST_VWAIT: begin
                    if (div_done) begin
                        state_reg <= ST_SQWAIT;
                    end
                end
                ST_SQWAIT: begin
                    if (sq_done) begin
                        rms_reg   <= sq_root[18:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Publish once the result register is free, then clear
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.trunc_mean <= mean_reg;
                        m_data_reg.trunc_rms  <= rms_reg;
                        m_data_reg.spread     <=
                            (samples_seen_reg != '0 && max_seen_reg >= min_seen_reg) ?
                            max_seen_reg - min_seen_reg : '0;
                        m_data_reg.kept_count <= k_reg;
                        clr_addr_reg     <= min_seen_reg;
                        clr_end_reg      <= max_seen_reg;
                        mode_value_reg   <= '0;
                        mode_count_reg   <= '0;
                        min_seen_reg     <= VMAX;
                        max_seen_reg     <= '0;
                        samples_seen_reg <= '0;
                        state_reg        <= ST_CLEAR;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/wbtm_checker.sv
// Port-level checker of the baseline estimator, bound to the top level.
// Depends on wbtm_pkg and the assertion macro header.
`include "waveform_baseline_truncated_mean_rms_defines.svh"

module wbtm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input wbtm_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input wbtm_pkg::out_item_t m_data
);

    `WBTM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `WBTM_ASSERT_NEXT(a_in_pace, s_valid && s_ready, !s_ready, "sample taken in consecutive cycles")
    `WBTM_ASSERT_NOW(a_kept_max, m_valid, m_data.kept_count <= 15'(wbtm_pkg::MAX_SAMPLES), "kept count too large")

endmodule

bind waveform_baseline_truncated_mean_rms wbtm_checker u_wbtm_checker (.*);
